@@ rtl/ec2d_pkg.sv @@
// Shared widths, types and helpers for the 2-D elastic collision datapath.
package ec2d_pkg;

  localparam int W     = 32;           // Q16.16 word
  localparam int DW    = W + 1;        // exact position / velocity difference
  localparam int SW    = 15;           // normalized direction magnitude
  localparam int SHW   = 5;            // normalizing shift amount
  localparam int BLW   = 6;            // bit length of a difference magnitude
  localparam int PW    = DW + SW + 1;  // dv_c * s_c product, signed
  localparam int DOTW  = PW + 1;       // dot product, signed
  localparam int DMW   = PW;           // dot magnitude, below 2^48
  localparam int DSW   = 2 * SW + 1;   // |s|^2
  localparam int MSW   = W + 1;        // mass sum, twice a mass
  localparam int CW    = 64;           // dot magnitude * component
  localparam int HW    = CW / 2;       // half of that, for partial products
  localparam int PPW   = MSW + HW;     // one partial product
  localparam int DENW  = 64;           // (m1+m2)*|s|^2
  localparam int NW    = PPW + HW + 1; // rounded numerator
  localparam int QW    = 35;           // quotient bits, change stays below 2^34
  localparam int OW    = QW + 3;       // new velocity before saturation
  localparam int LANES = 4;

  // lane order of the four velocity changes
  localparam int L_FX = 0;
  localparam int L_FY = 1;
  localparam int L_SX = 2;
  localparam int L_SY = 3;

  typedef struct packed {
    logic signed [W-1:0]  v1x;
    logic signed [W-1:0]  v1y;
    logic signed [W-1:0]  v2x;
    logic signed [W-1:0]  v2y;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [W-1:0]         m1;
    logic [W-1:0]         m2;
    logic                 byp;   // both masses zero: velocities pass through
  } item_t;

  typedef struct packed {
    logic signed [W-1:0] v1x;
    logic signed [W-1:0] v1y;
    logic signed [W-1:0] v2x;
    logic signed [W-1:0] v2y;
    logic [LANES-1:0]    neg;    // sign of each change magnitude
    logic                byp;
  } side_t;

  function automatic logic signed [W-1:0] sat_word(input logic signed [OW-1:0] v);
    logic signed [W-1:0] r;
    r = v[W-1:0];
    if (!v[OW-1] && (|v[OW-2:W-1])) r = {1'b0, {(W-1){1'b1}}};
    if (v[OW-1] && !(&v[OW-2:W-1])) r = {1'b1, {(W-1){1'b0}}};
    return r;
  endfunction

endpackage

@@ rtl/elastic_collision_2d.sv @@
// Two-disk elastic collision response, Q16.16 fixed point.
// Each transaction carries both disk centers, velocities and masses; the block
// returns both post-impact velocities. The normal is the line of centers,
// normalized by a shift to 15-bit components (coincident centers use the y
// axis). Velocity changes are 2*m*|dv.s|*|s_c| / ((m1+m2)*|s|^2), rounded half
// away from zero exactly, then added and saturated to 32 bits. If both masses
// are zero the velocities pass through. Throughput is one transaction per
// clock while the result side does not stall. The path from input to result is
// the front register, the queue, six datapath stages, 36 stages of the four
// pipelined restoring dividers (an input stage, then one quotient bit per stage)
// and the output register; the dividers make up most of that depth. The queue (QUEUE_DEPTH
// entries) lets the front keep accepting while the result side stalls.
module elastic_collision_2d import ec2d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [W-1:0] first_pos_x,
  input  logic signed [W-1:0] first_pos_y,
  input  logic signed [W-1:0] second_pos_x,
  input  logic signed [W-1:0] second_pos_y,
  input  logic signed [W-1:0] first_vel_x,
  input  logic signed [W-1:0] first_vel_y,
  input  logic signed [W-1:0] second_vel_x,
  input  logic signed [W-1:0] second_vel_y,
  input  logic [W-1:0]        first_mass,
  input  logic [W-1:0]        second_mass,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [W-1:0] first_new_vel_x,
  output logic signed [W-1:0] first_new_vel_y,
  output logic signed [W-1:0] second_new_vel_x,
  output logic signed [W-1:0] second_new_vel_y
);

  logic  q_push, q_full, q_pop, q_nonempty;
  item_t q_wdata, q_rdata;

  // front: registers the transaction and classifies the pair
  ec2d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .first_pos_x  (first_pos_x),
    .first_pos_y  (first_pos_y),
    .second_pos_x (second_pos_x),
    .second_pos_y (second_pos_y),
    .first_vel_x  (first_vel_x),
    .first_vel_y  (first_vel_y),
    .second_vel_x (second_vel_x),
    .second_vel_y (second_vel_y),
    .first_mass   (first_mass),
    .second_mass  (second_mass),
    .q_push       (q_push),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  // decoupling queue
  ec2d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  // back: stalls as one pipeline on the result handshake
  ec2d_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_nonempty),
    .q_pop            (q_pop),
    .q_data           (q_rdata),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .first_new_vel_x  (first_new_vel_x),
    .first_new_vel_y  (first_new_vel_y),
    .second_new_vel_x (second_new_vel_x),
    .second_new_vel_y (second_new_vel_y)
  );

endmodule

@@ rtl/ec2d_front.sv @@
// Front end: takes a transaction, forms center and velocity data, classifies the pair.
module ec2d_front import ec2d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [W-1:0] first_pos_x,
  input  logic signed [W-1:0] first_pos_y,
  input  logic signed [W-1:0] second_pos_x,
  input  logic signed [W-1:0] second_pos_y,
  input  logic signed [W-1:0] first_vel_x,
  input  logic signed [W-1:0] first_vel_y,
  input  logic signed [W-1:0] second_vel_x,
  input  logic signed [W-1:0] second_vel_y,
  input  logic [W-1:0]        first_mass,
  input  logic [W-1:0]        second_mass,
  output logic                q_push,
  output item_t               q_data,
  input  logic                q_full
);

  logic                hold;
  logic signed [W-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
  logic [W-1:0]        m1, m2;

  assign item_ready = !hold || !q_full;
  assign q_push     = hold && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (item_ready) begin
      hold <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      p1x <= first_pos_x;
      p1y <= first_pos_y;
      p2x <= second_pos_x;
      p2y <= second_pos_y;
      v1x <= first_vel_x;
      v1y <= first_vel_y;
      v2x <= second_vel_x;
      v2y <= second_vel_y;
      m1  <= first_mass;
      m2  <= second_mass;
    end
  end

  always_comb begin
    q_data.v1x = v1x;
    q_data.v1y = v1y;
    q_data.v2x = v2x;
    q_data.v2y = v2y;
    q_data.dx  = $signed({p2x[W-1], p2x}) - $signed({p1x[W-1], p1x});
    q_data.dy  = $signed({p2y[W-1], p2y}) - $signed({p1y[W-1], p1y});
    q_data.m1  = m1;
    q_data.m2  = m2;
    q_data.byp = (m1 == '0) && (m2 == '0);
  end

endmodule

@@ rtl/ec2d_fifo.sv @@
// Short queue between the front end and the datapath.
module ec2d_fifo import ec2d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  nonempty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [AW-1:0]   wp, rp, wp_next, rp_next;
  logic [CNTW-1:0] count;

  assign wp_next  = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign rp_next  = (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
  assign full     = (count == CNTW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp_next;
      if (pop) rp <= rp_next;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue popped while empty");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

@@ rtl/ec2d_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module ec2d_div import ec2d_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   quo
);

  logic [DENW-1:0] rem_q [QW+1];
  logic [QW-1:0]   qb    [QW+1];
  logic [DENW-1:0] dn    [QW+1];
  logic [DENW-1:0] rem_n [QW];
  logic [QW-1:0]   qb_n  [QW];
  logic [DENW:0]   trial [QW];
  logic [DENW:0]   diff  [QW];

  // remainder stays below den, so the trial fits DENW+1 bits
  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {rem_q[k], qb[k][QW-1]};
      diff[k]  = trial[k] - {1'b0, dn[k]};
      if (!diff[k][DENW]) begin
        rem_n[k] = diff[k][DENW-1:0];
        qb_n[k]  = {qb[k][QW-2:0], 1'b1};
      end else begin
        rem_n[k] = trial[k][DENW-1:0];
        qb_n[k]  = {qb[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= DENW'(num[NW-1:QW]);
      qb[0]    <= num[QW-1:0];
      dn[0]    <= den;
      for (int k = 0; k < QW; k++) begin
        rem_q[k+1] <= rem_n[k];
        qb[k+1]    <= qb_n[k];
        dn[k+1]    <= dn[k];
      end
    end
  end

  assign quo = qb[QW];

endmodule

@@ rtl/ec2d_back.sv @@
// Datapath: normalize, dot product, partial products, divide, saturate.
module ec2d_back import ec2d_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  item_t               q_data,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [W-1:0] first_new_vel_x,
  output logic signed [W-1:0] first_new_vel_y,
  output logic signed [W-1:0] second_new_vel_x,
  output logic signed [W-1:0] second_new_vel_y
);

  localparam int NST = 6 + QW + 2;

  logic           en;
  logic [NST-1:0] vld;

  assign en           = !result_valid || result_ready;
  assign q_pop        = en && q_valid;
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], q_valid};
    end
  end

  // stage 1: magnitudes and normalizing shift
  logic [DW-1:0]  ax_c, ay_c, omag;
  logic [BLW-1:0] blen;
  logic [SHW-1:0] sh_c;
  side_t          side_c;

  always_comb begin
    ax_c = q_data.dx[DW-1] ? DW'(-q_data.dx) : DW'(q_data.dx);
    ay_c = q_data.dy[DW-1] ? DW'(-q_data.dy) : DW'(q_data.dy);
    omag = ax_c | ay_c;
    blen = '0;
    for (int i = 0; i < DW; i++) begin
      if (omag[i]) blen = BLW'(i + 1);
    end
    sh_c = (blen > BLW'(SW)) ? SHW'(blen - BLW'(SW)) : '0;
    side_c.v1x = q_data.v1x;
    side_c.v1y = q_data.v1y;
    side_c.v2x = q_data.v2x;
    side_c.v2y = q_data.v2y;
    side_c.neg = '0;
    side_c.byp = q_data.byp;
  end

  logic [DW-1:0]         s1_ax, s1_ay;
  logic                  s1_nx, s1_ny;
  logic [SHW-1:0]        s1_sh;
  logic signed [DW-1:0]  s1_dvx, s1_dvy;
  logic [MSW-1:0]        s1_msum;
  logic [W-1:0]          s1_m1, s1_m2;
  side_t                 s1_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax   <= ax_c;
      s1_ay   <= ay_c;
      s1_nx   <= q_data.dx[DW-1];
      s1_ny   <= q_data.dy[DW-1];
      s1_sh   <= sh_c;
      s1_dvx  <= $signed({q_data.v2x[W-1], q_data.v2x}) - $signed({q_data.v1x[W-1], q_data.v1x});
      s1_dvy  <= $signed({q_data.v2y[W-1], q_data.v2y}) - $signed({q_data.v1y[W-1], q_data.v1y});
      s1_msum <= MSW'(q_data.m1) + MSW'(q_data.m2);
      s1_m1   <= q_data.m1;
      s1_m2   <= q_data.m2;
      s1_side <= side_c;
    end
  end

  // stage 2: shift, coincident centers fall back to the y axis
  logic [DW-1:0] axs, ays;
  logic [SW-1:0] axn_c, ayn_c;
  logic          ny_c;

  always_comb begin
    axs   = s1_ax >> s1_sh;
    ays   = s1_ay >> s1_sh;
    axn_c = axs[SW-1:0];
    ayn_c = ays[SW-1:0];
    ny_c  = s1_ny;
    if (axn_c == '0 && ayn_c == '0) begin
      ayn_c = SW'(1);
      ny_c  = 1'b0;
    end
  end

  logic [SW-1:0]        s2_axn, s2_ayn;
  logic                 s2_nx, s2_ny;
  logic signed [DW-1:0] s2_dvx, s2_dvy;
  logic [MSW-1:0]       s2_msum;
  logic [W-1:0]         s2_m1, s2_m2;
  side_t                s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_axn  <= axn_c;
      s2_ayn  <= ayn_c;
      s2_nx   <= s1_nx;
      s2_ny   <= ny_c;
      s2_dvx  <= s1_dvx;
      s2_dvy  <= s1_dvy;
      s2_msum <= s1_msum;
      s2_m1   <= s1_m1;
      s2_m2   <= s1_m2;
      s2_side <= s1_side;
    end
  end

  // stage 3: dv_c * s_c and |s|^2
  logic signed [SW:0]   sxs, sys;
  logic signed [PW-1:0] px_c, py_c;
  logic [DSW-1:0]       dsq_c;

  always_comb begin
    sxs   = s2_nx ? -$signed({1'b0, s2_axn}) : $signed({1'b0, s2_axn});
    sys   = s2_ny ? -$signed({1'b0, s2_ayn}) : $signed({1'b0, s2_ayn});
    px_c  = s2_dvx * sxs;
    py_c  = s2_dvy * sys;
    dsq_c = DSW'(s2_axn) * DSW'(s2_axn) + DSW'(s2_ayn) * DSW'(s2_ayn);
  end

  logic signed [PW-1:0] s3_px, s3_py;
  logic [DSW-1:0]       s3_dsq;
  logic [SW-1:0]        s3_axn, s3_ayn;
  logic                 s3_nx, s3_ny;
  logic [MSW-1:0]       s3_msum;
  logic [W-1:0]         s3_m1, s3_m2;
  side_t                s3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_px   <= px_c;
      s3_py   <= py_c;
      s3_dsq  <= dsq_c;
      s3_axn  <= s2_axn;
      s3_ayn  <= s2_ayn;
      s3_nx   <= s2_nx;
      s3_ny   <= s2_ny;
      s3_msum <= s2_msum;
      s3_m1   <= s2_m1;
      s3_m2   <= s2_m2;
      s3_side <= s2_side;
    end
  end

  // stage 4: dot product magnitude and denominator
  logic signed [DOTW-1:0] dot_c, dotn_c;

  always_comb begin
    dot_c  = $signed({s3_px[PW-1], s3_px}) + $signed({s3_py[PW-1], s3_py});
    dotn_c = -dot_c;
  end

  logic [DMW-1:0]  s4_dotmag;
  logic            s4_nd;
  logic [DENW-1:0] s4_den;
  logic [SW-1:0]   s4_axn, s4_ayn;
  logic            s4_nx, s4_ny;
  logic [W-1:0]    s4_m1, s4_m2;
  side_t           s4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_dotmag <= dot_c[DOTW-1] ? dotn_c[DMW-1:0] : dot_c[DMW-1:0];
      s4_nd     <= dot_c[DOTW-1];
      s4_den    <= DENW'(s3_msum) * DENW'(s3_dsq);
      s4_axn    <= s3_axn;
      s4_ayn    <= s3_ayn;
      s4_nx     <= s3_nx;
      s4_ny     <= s3_ny;
      s4_m1     <= s3_m1;
      s4_m2     <= s3_m2;
      s4_side   <= s3_side;
    end
  end

  // stage 5: dot magnitude times each component, change signs
  side_t side5_c;

  always_comb begin
    side5_c           = s4_side;
    side5_c.neg[L_FX] = s4_nd ^ s4_nx;
    side5_c.neg[L_FY] = s4_nd ^ s4_ny;
    side5_c.neg[L_SX] = s4_nd ^ s4_nx;
    side5_c.neg[L_SY] = s4_nd ^ s4_ny;
  end

  logic [CW-1:0]   s5_cx, s5_cy;
  logic [MSW-1:0]  s5_tm1, s5_tm2;
  logic [DENW-1:0] s5_den;
  side_t           s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cx   <= CW'(s4_dotmag) * CW'(s4_axn);
      s5_cy   <= CW'(s4_dotmag) * CW'(s4_ayn);
      s5_tm1  <= {s4_m1, 1'b0};
      s5_tm2  <= {s4_m2, 1'b0};
      s5_den  <= s4_den;
      s5_side <= side5_c;
    end
  end

  // stage 6: 2m * c split in two partial products per lane
  logic [MSW-1:0] tm_c [LANES];
  logic [CW-1:0]  cc_c [LANES];
  logic [PPW-1:0] s6_pl [LANES];
  logic [PPW-1:0] s6_ph [LANES];
  logic [DENW-1:0] s6_den;
  side_t           s6_side;

  always_comb begin
    tm_c[L_FX] = s5_tm2;
    tm_c[L_FY] = s5_tm2;
    tm_c[L_SX] = s5_tm1;
    tm_c[L_SY] = s5_tm1;
    cc_c[L_FX] = s5_cx;
    cc_c[L_FY] = s5_cy;
    cc_c[L_SX] = s5_cx;
    cc_c[L_SY] = s5_cy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        s6_pl[k] <= PPW'(tm_c[k]) * PPW'(cc_c[k][HW-1:0]);
        s6_ph[k] <= PPW'(tm_c[k]) * PPW'(cc_c[k][CW-1:HW]);
      end
      s6_den  <= s5_den;
      s6_side <= s5_side;
    end
  end

  // rounded numerator, then one divider per lane
  logic [NW-1:0] num_c [LANES];
  logic [QW-1:0] quo   [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      num_c[k] = NW'(s6_pl[k]) + (NW'(s6_ph[k]) << HW) + NW'(s6_den >> 1);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_div
    ec2d_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_c[g]),
      .den (s6_den),
      .quo (quo[g])
    );
  end

  side_t side_d [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= s6_side;
      for (int k = 0; k < QW; k++) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  // final stage: apply changes, saturate
  logic signed [OW-1:0] chg [LANES];
  logic signed [OW-1:0] sum [LANES];
  side_t                sd;

  always_comb begin
    sd = side_d[QW];
    for (int k = 0; k < LANES; k++) begin
      chg[k] = sd.neg[k] ? -$signed({3'b000, quo[k]}) : $signed({3'b000, quo[k]});
    end
    sum[L_FX] = OW'(sd.v1x) + chg[L_FX];
    sum[L_FY] = OW'(sd.v1y) + chg[L_FY];
    sum[L_SX] = OW'(sd.v2x) - chg[L_SX];
    sum[L_SY] = OW'(sd.v2y) - chg[L_SY];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd.byp) begin
        first_new_vel_x  <= sd.v1x;
        first_new_vel_y  <= sd.v1y;
        second_new_vel_x <= sd.v2x;
        second_new_vel_y <= sd.v2y;
      end else begin
        first_new_vel_x  <= sat_word(sum[L_FX]);
        first_new_vel_y  <= sat_word(sum[L_FY]);
        second_new_vel_x <= sat_word(sum[L_SX]);
        second_new_vel_y <= sat_word(sum[L_SY]);
      end
    end
  end

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-2] && !sd.byp) |->
      (!quo[L_FX][QW-1] && !quo[L_FY][QW-1] && !quo[L_SX][QW-1] && !quo[L_SY][QW-1]))
    else $error("velocity change out of range");
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (en && vld[NST-2] && sd.byp) |=> first_new_vel_x == $past(sd.v1x))
    else $error("zero-mass pair not passed through");

endmodule

@@ verif/tb_elastic_collision_2d.sv @@
// Self-checking testbench for the two-disk elastic collision response block.
module tb_elastic_collision_2d;
  import ec2d_pkg::*;

  typedef struct {
    logic signed [W-1:0] p1x, p1y, p2x, p2y;
    logic signed [W-1:0] v1x, v1y, v2x, v2y;
    logic [W-1:0]        m1, m2;
  } collision_t;

  typedef struct {
    logic signed [W-1:0] fx, fy, sx, sy;
  } rebound_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [W-1:0] first_pos_x = '0, first_pos_y = '0;
  logic signed [W-1:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [W-1:0] first_vel_x = '0, first_vel_y = '0;
  logic signed [W-1:0] second_vel_x = '0, second_vel_y = '0;
  logic [W-1:0] first_mass = 32'd1, second_mass = 32'd1;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [W-1:0] first_new_vel_x, first_new_vel_y;
  logic signed [W-1:0] second_new_vel_x, second_new_vel_y;

  rebound_t pending_rebounds[$];
  int       error_count = 0;
  bit       hold_results = 1'b0;

  elastic_collision_2d dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // velocity change of one lane: round(tm*dm*comp/den), half away from zero
  function automatic longint lane_change(logic [63:0] tm, logic [63:0] dm,
                                         logic [63:0] comp, bit neg, logic [63:0] den);
    logic [63:0]  prod;
    logic [127:0] num;
    logic [127:0] q;
    prod = dm * comp;
    num  = {64'b0, tm} * {64'b0, prod};
    num  = num + {64'b0, den >> 1};
    q    = num / {64'b0, den};
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [W-1:0] clamp_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[W-1:0];
  endfunction

  function automatic rebound_t predict_rebound(collision_t c);
    rebound_t    r;
    longint      dx, dy, sx, sy, dot, v1x, v1y, v2x, v2y;
    logic [63:0] ax, ay, msum, dotmag, dsq, den;
    bit          nx, ny, nd;
    v1x = c.v1x; v1y = c.v1y; v2x = c.v2x; v2y = c.v2y;
    dx = longint'(c.p2x) - longint'(c.p1x);
    dy = longint'(c.p2y) - longint'(c.p1y);
    msum = {32'b0, c.m1} + {32'b0, c.m2};
    if (msum == 0) begin
      r.fx = c.v1x; r.fy = c.v1y; r.sx = c.v2x; r.sy = c.v2y;
      return r;
    end
    nx = dx < 0; ny = dy < 0;
    ax = nx ? -dx : dx;
    ay = ny ? -dy : dy;
    // shift both together until each fits in 15 bits
    while (ax >= 32768 || ay >= 32768) begin
      ax = ax >> 1; ay = ay >> 1;
    end
    // coincident centers: normal is the y axis
    if (ax == 0 && ay == 0) begin
      ay = 1; ny = 1'b0;
    end
    sx = nx ? -longint'(ax) : longint'(ax);
    sy = ny ? -longint'(ay) : longint'(ay);
    dot = (v2x - v1x) * sx + (v2y - v1y) * sy;
    nd = dot < 0;
    dotmag = nd ? -dot : dot;
    dsq = ax * ax + ay * ay;
    den = msum * dsq;
    r.fx = clamp_word(v1x + lane_change({31'b0, c.m2, 1'b0}, dotmag, ax, nd != nx, den));
    r.fy = clamp_word(v1y + lane_change({31'b0, c.m2, 1'b0}, dotmag, ay, nd != ny, den));
    r.sx = clamp_word(v2x - lane_change({31'b0, c.m1, 1'b0}, dotmag, ax, nd != nx, den));
    r.sy = clamp_word(v2y - lane_change({31'b0, c.m1, 1'b0}, dotmag, ay, nd != ny, den));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // offer one collision after a random gap; returns once accepted
  task automatic send_collision(collision_t c);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    first_pos_x  <= c.p1x; first_pos_y  <= c.p1y;
    second_pos_x <= c.p2x; second_pos_y <= c.p2y;
    first_vel_x  <= c.v1x; first_vel_y  <= c.v1y;
    second_vel_x <= c.v2x; second_vel_y <= c.v2y;
    first_mass   <= c.m1;  second_mass  <= c.m2;
    do @(posedge clk); while (!(item_valid && item_ready));
    pending_rebounds.push_back(predict_rebound(c));
  endtask

  task automatic finish_stream();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [W-1:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] any_mass();
    case ($urandom_range(0, 5))
      0: return 32'hffffffff;
      1: return 32'd1;
      2: return $urandom_range(1, 32'h40000);
      default: begin
        any_mass = $urandom;
        if (any_mass == 0) any_mass = 32'd1;
      end
    endcase
  endfunction

  // mostly disks in contact at modest scale, sometimes full-range words
  function automatic collision_t random_collision();
    collision_t c;
    int         scale;
    scale = $urandom_range(4, 31);
    c.p1x = $urandom; c.p1y = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      c.p2x = any_word(); c.p2y = any_word();
    end else begin
      c.p2x = c.p1x + ($signed($urandom) >>> scale);
      c.p2y = c.p1y + ($signed($urandom) >>> scale);
      if ($urandom_range(0, 15) == 0) c.p2x = c.p1x;
    end
    c.v1x = any_word(); c.v1y = any_word();
    c.v2x = any_word(); c.v2y = any_word();
    if ($urandom_range(0, 1)) begin
      c.v1x = $signed(c.v1x) >>> 12; c.v1y = $signed(c.v1y) >>> 12;
      c.v2x = $signed(c.v2x) >>> 12; c.v2y = $signed(c.v2y) >>> 12;
    end
    c.m1 = any_mass(); c.m2 = any_mass();
    return c;
  endfunction

  function automatic collision_t make_collision(logic [W-1:0] p1x, p1y, p2x, p2y,
      v1x, v1y, v2x, v2y, m1, m2);
    collision_t c;
    c.p1x = p1x; c.p1y = p1y; c.p2x = p2x; c.p2y = p2y;
    c.v1x = v1x; c.v1y = v1y; c.v2x = v2x; c.v2y = v2y;
    c.m1 = m1; c.m2 = m2;
    return c;
  endfunction

  task automatic test_directed();
    // head-on, equal masses
    send_collision(make_collision(0, 0, 32'h20000, 0, 32'h10000, 0, 32'hffff0000, 0,
                                  32'h10000, 32'h10000));
    // equal x: normal along y
    send_collision(make_collision(32'h5000, 0, 32'h5000, 32'h30000, 32'h7000, 32'h10000,
                                  32'h3000, 32'hfff00000, 32'h20000, 32'h10000));
    // coincident centers
    send_collision(make_collision(32'h1234, 32'h5678, 32'h1234, 32'h5678, 32'h10000,
                                  32'h20000, 32'hfffe0000, 32'h4000, 32'h10000, 32'h30000));
    // widest separation, both directions
    send_collision(make_collision(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                  32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'hffffffff, 32'hffffffff));
    send_collision(make_collision(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                                  32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                  32'd1, 32'hffffffff));
    // saturation with lopsided masses
    send_collision(make_collision(0, 0, 32'h10000, 32'h10000, 32'h80000000, 32'h80000000,
                                  32'h7fffffff, 32'h7fffffff, 32'd1, 32'hffffffff));
    send_collision(make_collision(0, 0, 32'hffff0000, 32'h1, 32'h7fffffff, 32'h0,
                                  32'h80000000, 32'h0, 32'hffffffff, 32'd1));
    // separating disks still exchange
    send_collision(make_collision(0, 0, 32'h20000, 0, 32'hffff0000, 0, 32'h10000, 0,
                                  32'h10000, 32'h10000));
    // tiny offsets, all-ones and zero velocities
    send_collision(make_collision(32'hffffffff, 0, 0, 32'hffffffff, 32'hffffffff,
                                  32'hffffffff, 0, 0, 32'd1, 32'd1));
    send_collision(make_collision(0, 0, 32'h1, 32'h0, 0, 0, 0, 0, 32'd3, 32'd5));
    finish_stream();
  endtask

  task automatic test_random(int count);
    repeat (count) send_collision(random_collision());
    finish_stream();
  endtask

  // receiver holds off long enough for the queue to fill and the input to stall
  task automatic test_backpressure();
    hold_results = 1'b1;
    repeat (120) send_collision(random_collision());
    finish_stream();
  endtask

  // sender waits for the pipe to drain before continuing
  task automatic test_drain_pause();
    repeat (20) send_collision(random_collision());
    finish_stream();
    wait (pending_rebounds.size() == 0);
    @(posedge clk);
    repeat (20) send_collision(random_collision());
    finish_stream();
  endtask

  // result side: random stalls per transaction, plus one long hold-off
  initial begin
    int wait_cycles;
    wait (!rst);
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_results = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        result_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    rebound_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_rebounds.size() == 0) begin
        $display("result transaction with no prediction pending");
        error_count++;
      end else begin
        want = pending_rebounds.pop_front();
        if (first_new_vel_x !== want.fx)
          report_mismatch("first_new_vel_x", first_new_vel_x, want.fx);
        if (first_new_vel_y !== want.fy)
          report_mismatch("first_new_vel_y", first_new_vel_y, want.fy);
        if (second_new_vel_x !== want.sx)
          report_mismatch("second_new_vel_x", second_new_vel_x, want.sx);
        if (second_new_vel_y !== want.sy)
          report_mismatch("second_new_vel_y", second_new_vel_y, want.sy);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_drain_pause();
    test_random(640);
    wait (pending_rebounds.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("** elastic_collision_2d: PASSED **");
    else
      $display("** elastic_collision_2d: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("** elastic_collision_2d: FAILED **");
    $finish;
  end

endmodule
